### hdl/pudp_pkg.sv
// ----------------------------------------------------------------------------
// pudp_pkg
// Shared types and constants of the presentation user-data parser.
// ----------------------------------------------------------------------------
package pudp_pkg;

  // Default message size limit, in bytes.
  localparam int MAX_MESSAGE_BYTES = 4096;

  // A message shorter than this always reports too short.
  localparam int MIN_MESSAGE_BYTES = 9;

  // Widths of the result fields.
  localparam int STATUS_W = 4;
  localparam int CTX_W    = 8;
  localparam int OFFSET_W = 12;
  localparam int LENGTH_W = 7;

  // Tags and fixed bytes of the encoding.
  localparam logic [7:0] TAG_OUTER   = 8'h61;
  localparam logic [7:0] TAG_SEQ     = 8'h30;
  localparam logic [7:0] TAG_CONTEXT = 8'h02;
  localparam logic [7:0] TAG_SYNTAX  = 8'h06;
  localparam logic [7:0] TAG_DATA    = 8'ha0;
  localparam logic [7:0] SYNTAX_B0   = 8'h51;
  localparam logic [7:0] SYNTAX_B1   = 8'h01;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_OUTER  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SEQ    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_LONG_LEN   = 4'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN   = 4'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_SYNTAX = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NO_CONTEXT = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NO_DATA    = 4'd8;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_OUTER_TAG,
    PH_OUTER_LEN,
    PH_SEQ_TAG,
    PH_SEQ_LEN,
    PH_ITEM_TAG,
    PH_ITEM_LEN,
    PH_CONTENT,
    PH_DECIDED,
    PH_DRAIN
  } phase_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CTX_W-1:0]    context_id;
    logic [OFFSET_W-1:0] data_offset;
    logic [LENGTH_W-1:0] data_length;
  } result_t;

endpackage

### hdl/pudp_in_if.sv
// ----------------------------------------------------------------------------
// pudp_in_if
// Byte stream channel into the parser: one message byte and its last mark.
// ----------------------------------------------------------------------------
interface pudp_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

### hdl/pudp_out_if.sv
// ----------------------------------------------------------------------------
// pudp_out_if
// Result channel out of the parser: one parse outcome per message.
// ----------------------------------------------------------------------------
interface pudp_out_if;

  logic                           valid;
  logic                           ready;
  logic [pudp_pkg::STATUS_W-1:0]  status;
  logic [pudp_pkg::CTX_W-1:0]     context_id;
  logic [pudp_pkg::OFFSET_W-1:0]  data_offset;
  logic [pudp_pkg::LENGTH_W-1:0]  data_length;

  modport source (output valid, output status, output context_id, output data_offset,
                  output data_length, input ready);
  modport sink   (input valid, input status, input context_id, input data_offset,
                  input data_length, output ready);

endinterface

### hdl/pudp_parser.sv
// ----------------------------------------------------------------------------
// pudp_parser
// Parse state and the one-byte step of the tag-length-value walk.
// ----------------------------------------------------------------------------
module pudp_parser #(
  parameter int MAX_MESSAGE_BYTES = pudp_pkg::MAX_MESSAGE_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                emit,
  output pudp_pkg::result_t   result
);

  localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int CNT_W = POS_W + 1;
  localparam int OFF_W = pudp_pkg::OFFSET_W;
  localparam int LEN_W = pudp_pkg::LENGTH_W;
  localparam int ST_W  = pudp_pkg::STATUS_W;

  pudp_pkg::phase_t phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [LEN_W-1:0] content_left, content_left_next;
  logic [7:0]       item_tag, item_tag_next;
  logic             context_seen, context_seen_next;
  logic [7:0]       saved_context, saved_context_next;
  logic [1:0]       content_index, content_index_next;
  logic [ST_W-1:0]  held_status, held_status_next;
  logic [OFF_W-1:0] held_offset, held_offset_next;
  logic [LEN_W-1:0] held_length, held_length_next;

  logic [CNT_W-1:0] count;
  logic             clear_all;

  assign count = CNT_W'(byte_position) + CNT_W'(1);

  // One byte step: parse, count, then decide whether a result goes out.
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    content_left_next  = content_left;
    item_tag_next      = item_tag;
    context_seen_next  = context_seen;
    saved_context_next = saved_context;
    content_index_next = content_index;
    held_status_next   = held_status;
    held_offset_next   = held_offset;
    held_length_next   = held_length;
    clear_all          = 1'b0;
    emit               = 1'b0;
    result             = '0;

    if (step) begin
      if (phase == pudp_pkg::PH_DRAIN) begin
        clear_all = last_byte;
      end else begin
        // Parse the byte unless the outcome is already held.
        case (phase)
          pudp_pkg::PH_OUTER_TAG: begin
            if (data_byte != pudp_pkg::TAG_OUTER) begin
              held_status_next = pudp_pkg::ST_BAD_OUTER;
              phase_next       = pudp_pkg::PH_DECIDED;
            end else begin
              phase_next = pudp_pkg::PH_OUTER_LEN;
            end
          end
          pudp_pkg::PH_OUTER_LEN: begin
            priority if (data_byte[7]) begin
              held_status_next = pudp_pkg::ST_LONG_LEN;
              phase_next       = pudp_pkg::PH_DECIDED;
            end else if (data_byte == 8'd0) begin
              held_status_next = pudp_pkg::ST_ZERO_LEN;
              phase_next       = pudp_pkg::PH_DECIDED;
            end else begin
              phase_next = pudp_pkg::PH_SEQ_TAG;
            end
          end
          pudp_pkg::PH_SEQ_TAG: begin
            if (data_byte != pudp_pkg::TAG_SEQ) begin
              held_status_next = pudp_pkg::ST_BAD_SEQ;
              phase_next       = pudp_pkg::PH_DECIDED;
            end else begin
              phase_next = pudp_pkg::PH_SEQ_LEN;
            end
          end
          pudp_pkg::PH_SEQ_LEN: begin
            if (data_byte[7]) begin
              held_status_next = pudp_pkg::ST_LONG_LEN;
              phase_next       = pudp_pkg::PH_DECIDED;
            end else begin
              phase_next = pudp_pkg::PH_ITEM_TAG;
            end
          end
          pudp_pkg::PH_ITEM_TAG: begin
            item_tag_next = data_byte;
            phase_next    = pudp_pkg::PH_ITEM_LEN;
          end
          pudp_pkg::PH_ITEM_LEN: begin
            content_left_next  = data_byte[LEN_W-1:0];
            content_index_next = 2'd0;
            priority if (data_byte[7]) begin
              held_status_next = pudp_pkg::ST_LONG_LEN;
              phase_next       = pudp_pkg::PH_DECIDED;
            end else if (item_tag == pudp_pkg::TAG_DATA) begin
              if (!context_seen) begin
                held_status_next = pudp_pkg::ST_NO_CONTEXT;
              end else begin
                held_status_next = pudp_pkg::ST_OK;
                held_offset_next = OFF_W'(count);
                held_length_next = data_byte[LEN_W-1:0];
              end
              phase_next = pudp_pkg::PH_DECIDED;
            end else if (item_tag == pudp_pkg::TAG_CONTEXT) begin
              context_seen_next = 1'b1;
              if (data_byte == 8'd0) begin
                saved_context_next = 8'd0;
                phase_next         = pudp_pkg::PH_ITEM_TAG;
              end else begin
                phase_next = pudp_pkg::PH_CONTENT;
              end
            end else if (item_tag == pudp_pkg::TAG_SYNTAX) begin
              if (data_byte < 8'd2) begin
                held_status_next = pudp_pkg::ST_BAD_SYNTAX;
                phase_next       = pudp_pkg::PH_DECIDED;
              end else begin
                phase_next = pudp_pkg::PH_CONTENT;
              end
            end else begin
              phase_next = (data_byte == 8'd0) ? pudp_pkg::PH_ITEM_TAG
                                               : pudp_pkg::PH_CONTENT;
            end
          end
          pudp_pkg::PH_CONTENT: begin
            if (item_tag == pudp_pkg::TAG_CONTEXT && content_index == 2'd0) begin
              saved_context_next = data_byte;
            end
            // The transfer syntax item must open with its two fixed bytes.
            if (item_tag == pudp_pkg::TAG_SYNTAX &&
                ((content_index == 2'd0 && data_byte != pudp_pkg::SYNTAX_B0) ||
                 (content_index == 2'd1 && data_byte != pudp_pkg::SYNTAX_B1))) begin
              held_status_next = pudp_pkg::ST_BAD_SYNTAX;
              phase_next       = pudp_pkg::PH_DECIDED;
            end else begin
              if (content_index != 2'd2) begin
                content_index_next = content_index + 2'd1;
              end
              if (content_left <= LEN_W'(1)) begin
                content_left_next = '0;
                phase_next        = pudp_pkg::PH_ITEM_TAG;
              end else begin
                content_left_next = content_left - LEN_W'(1);
              end
            end
          end
          default: begin
          end
        endcase

        // The byte counter stops at the size limit.
        if (byte_position < POS_W'(MAX_MESSAGE_BYTES)) begin
          byte_position_next = count[POS_W-1:0];
        end

        // Result selection: too short wins, then a held outcome, then no data.
        priority if (last_byte && count < CNT_W'(pudp_pkg::MIN_MESSAGE_BYTES)) begin
          emit          = 1'b1;
          result.status = pudp_pkg::ST_SHORT;
        end else if (phase_next == pudp_pkg::PH_DECIDED) begin
          if (count >= CNT_W'(pudp_pkg::MIN_MESSAGE_BYTES)) begin
            emit          = 1'b1;
            result.status = held_status_next;
            if (held_status_next == pudp_pkg::ST_OK) begin
              result.context_id  = saved_context_next;
              result.data_offset = held_offset_next;
              result.data_length = held_length_next;
            end
          end
        end else if (last_byte || count >= CNT_W'(MAX_MESSAGE_BYTES)) begin
          emit          = 1'b1;
          result.status = pudp_pkg::ST_NO_DATA;
        end

        if (last_byte) begin
          clear_all = 1'b1;
        end else if (emit) begin
          phase_next = pudp_pkg::PH_DRAIN;
        end
      end
    end

    // The final byte of a message returns everything to the start state.
    if (clear_all) begin
      phase_next         = pudp_pkg::PH_OUTER_TAG;
      byte_position_next = '0;
      content_left_next  = '0;
      item_tag_next      = '0;
      context_seen_next  = 1'b0;
      saved_context_next = '0;
      content_index_next = '0;
      held_status_next   = '0;
      held_offset_next   = '0;
      held_length_next   = '0;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pudp_pkg::PH_OUTER_TAG;
      byte_position <= '0;
      content_left  <= '0;
      item_tag      <= '0;
      context_seen  <= 1'b0;
      saved_context <= '0;
      content_index <= '0;
      held_status   <= '0;
      held_offset   <= '0;
      held_length   <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      content_left  <= content_left_next;
      item_tag      <= item_tag_next;
      context_seen  <= context_seen_next;
      saved_context <= saved_context_next;
      content_index <= content_index_next;
      held_status   <= held_status_next;
      held_offset   <= held_offset_next;
      held_length   <= held_length_next;
    end
  end

endmodule

### hdl/presentation_user_data_parser_unit.sv
// ----------------------------------------------------------------------------
// presentation_user_data_parser_unit
// Parses a presentation-layer message byte by byte and reports one outcome.
// ----------------------------------------------------------------------------
//  Port  Kind             Payload
//  msg   byte stream in   data_byte[7:0], last_byte
//  res   result out       status[3:0], context_id[7:0], data_offset[11:0],
//                         data_length[6:0]
//
//  One byte per cycle sustained while results are taken; a byte goes from
//  request to result through the input register, then the parse step into
//  the result register. Reset clears the parse state and both stages.
//  A byte waits in the input register only while the result register
//  holds a result that has not been taken.
// ----------------------------------------------------------------------------
module presentation_user_data_parser_unit #(
  parameter int MAX_MESSAGE_BYTES = pudp_pkg::MAX_MESSAGE_BYTES
) (
  input  logic       clk,
  input  logic       rst,
  pudp_in_if.sink    msg,
  pudp_out_if.source res
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              in_last;
  logic              advance;
  logic              step;
  logic              emit;
  pudp_pkg::result_t step_result;
  logic              out_valid;
  pudp_pkg::result_t out_result;

  // The byte moves on whenever the result register is free or being taken.
  assign advance   = !out_valid || res.ready;
  assign step      = in_valid && advance;
  assign msg.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (msg.valid && msg.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      in_byte <= msg.data_byte;
      in_last <= msg.last_byte;
    end
  end

  pudp_parser #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .emit      (emit),
    .result    (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_result <= step_result;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_result.status;
  assign res.context_id  = out_result.context_id;
  assign res.data_offset = out_result.data_offset;
  assign res.data_length = out_result.data_length;

endmodule
